### sv/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg: shared types and constants for the pulse beat detector
// Register indexes, reset values, controller states and the divider request
// and response types.
// ----------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

  localparam int WINDOW_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam int WLEN_BITS      = 11;
  localparam int KEEP_BITS      = 16;
  localparam int STAMP_BITS     = 32;
  localparam int COUNT_BITS     = 32;
  localparam int ACC_BITS       = 64;
  localparam int ENERGY_BITS    = 48;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_KEEP = 1'b1;

  localparam logic [WLEN_BITS-1:0] WLEN_RESET = 11'd256;
  localparam logic [KEEP_BITS-1:0] KEEP_RESET = 16'd21845;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVICT,
    S_EVICT_RD,
    S_WRITE,
    S_SCAN,
    S_MEAN,
    S_MEAN_WAIT,
    S_MUL_LO,
    S_MUL_HI,
    S_DECIDE,
    S_E_CM,
    S_E_T,
    S_E_MUL,
    S_P_DIV,
    S_P_WAIT,
    S_PUT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [ACC_BITS-1:0]   num;
    logic [COUNT_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [ACC_BITS-1:0] quo;
  } div_rsp_t;

  function automatic logic [ENERGY_BITS-1:0] sat48(input logic [ACC_BITS-1:0] x);
    logic [ENERGY_BITS-1:0] r;
    if (x[ACC_BITS-1:ENERGY_BITS] != '0) begin
      r = '1;
    end else begin
      r = x[ENERGY_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/pbd_sdiv.sv
// ----------------------------------------------------------------------------
// pbd_sdiv: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_sdiv (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pbd_pkg::div_req_t req,
  output pbd_pkg::div_rsp_t     rsp
);
  import pbd_pkg::*;

  localparam int CW = $clog2(ACC_BITS + 1);

  logic [COUNT_BITS:0]   rem_r;
  logic [ACC_BITS-1:0]   quo_r;
  logic [COUNT_BITS-1:0] den_r;
  logic [CW-1:0]         cnt_r;
  logic                  done_r;

  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS+1:0] diff;
  logic                  ge;

  assign rem_sh = {rem_r[COUNT_BITS-1:0], quo_r[ACC_BITS-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = ~diff[COUNT_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= CW'(ACC_BITS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[COUNT_BITS:0] : rem_sh;
      quo_r <= {quo_r[ACC_BITS-2:0], ge};
    end
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

### sv/pulse_beat_detector_unit.sv
// ----------------------------------------------------------------------------
// pulse_beat_detector_unit: adaptive threshold beat detector
// Sliding window statistics, trough/peak search and serial beat energy.
// ----------------------------------------------------------------------------
// One sample word is taken at a time; in_stall stays high until the word is
// fully processed. Each word passes through window upkeep (evicting E old
// samples, usually one, writing the new one and scanning the F entries of
// the window fill after the write, one memory read per cycle), the mean in
// the shared bit-serial divider, the thresholds and the decision. A word
// that closes a reported beat also takes a shift-add multiply for the
// energy and a second pass through the divider for power.
// The window memory has one write and one read port with registered read
// data; it needs no clearing after reset because only written entries are
// read. A beat word waits in the output register while out_stall is high;
// the next sample is accepted meanwhile, and a new beat is held back only
// until the previous word has left.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_beat_detector_unit #(
  parameter int WINDOW_DEPTH = pbd_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = pbd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [pbd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [pbd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  wire logic [pbd_pkg::STAMP_BITS-1:0]       in_sample_time,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [pbd_pkg::STAMP_BITS-1:0]            out_beat_begin,
  output logic [pbd_pkg::STAMP_BITS-1:0]            out_duration,
  output logic signed [SAMPLE_BITS-1:0]             out_peak_value,
  output logic signed [SAMPLE_BITS-1:0]             out_trough_value,
  output logic [pbd_pkg::ENERGY_BITS-1:0]           out_energy,
  output logic [pbd_pkg::ENERGY_BITS-1:0]           out_power
);
  import pbd_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW  = $clog2(WINDOW_DEPTH + 1);
  localparam int TW  = SB + FW + 1;        // window total, signed
  localparam int PW  = SB + 18;            // keep * (mean - extreme)
  localparam int QW  = SB + 20;            // thresholds scaled by 2^16
  localparam int SQW = 2 * SB;
  localparam int CMW = COUNT_BITS + 1 + SB;
  localparam int KW  = $clog2(SB + 1);

  // configuration
  logic [WLEN_BITS-1:0] wlen_r;
  logic [KEEP_BITS-1:0] keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RESET;
      keep_r <= KEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH:  wlen_r <= cfg_data[WLEN_BITS-1:0];
        CFG_THRESHOLD_KEEP: keep_r <= cfg_data[KEEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // controller
  state_t state_r, state_nxt;

  // window
  logic signed [SB-1:0] mem [WINDOW_DEPTH];
  logic signed [SB-1:0] rd_data_r;
  logic [AW-1:0]        head_r;
  logic [FW-1:0]        fill_r;
  logic [FW-1:0]        len_r;
  logic signed [TW-1:0] total_r;
  logic                 ovf_r;

  // current word
  logic signed [SB-1:0]  v_r;
  logic [STAMP_BITS-1:0] vt_r;

  // scan
  logic [AW-1:0]        scan_ptr_r;
  logic [FW-1:0]        scan_cnt_r;
  logic                 pend_r;
  logic signed [SB-1:0] mn_r, mx_r;

  // thresholds
  logic signed [SB-1:0]  mean_r;
  logic signed [PW-1:0]  prod_lo_r, prod_hi_r;
  logic [SQW-1:0]        sq_r;

  // search state
  logic                  seek_r;
  logic signed [SB-1:0]  trough_r, peak_r;
  logic [STAMP_BITS-1:0] tstamp_r, pstamp_r;
  logic [COUNT_BITS-1:0] acc_cnt_r, snap_cnt_r;
  logic [ACC_BITS-1:0]   acc_sum_r, acc_sq_r, snap_sum_r, snap_sq_r;

  // beat under construction
  logic [STAMP_BITS-1:0] beat_start_r, beat_dur_r;
  logic signed [SB-1:0]  beat_peak_r, beat_trough_r;
  logic [ACC_BITS-1:0]   cm_r, tm_r, e_r;
  logic [SB-1:0]         msh_r;
  logic [KW-1:0]         k_r;

  // output register
  logic                  out_valid_r;

  // divider
  div_req_t dreq;
  div_rsp_t drsp;

  pbd_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // combinational helpers
  logic          in_acc;
  logic          evict_need;
  logic          scan_more;
  logic [31:0]   oa32;
  logic [AW-1:0] old_addr;
  logic [31:0]   len32;
  logic          mem_we;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          out_free;
  logic          emit;

  assign in_acc     = in_valid && !in_stall;
  assign evict_need = (fill_r >= len_r);
  assign scan_more  = (scan_cnt_r != fill_r);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    if (32'(head_r) >= 32'(fill_r)) begin
      oa32 = 32'(head_r) - 32'(fill_r);
    end else begin
      oa32 = 32'(head_r) + 32'(WINDOW_DEPTH) - 32'(fill_r);
    end
    old_addr = oa32[AW-1:0];
  end

  // 0 acts as 1, beyond the memory acts as the memory depth
  always_comb begin
    if (wlen_r == '0) begin
      len32 = 32'd1;
    end else if (32'(wlen_r) > 32'(WINDOW_DEPTH)) begin
      len32 = 32'(WINDOW_DEPTH);
    end else begin
      len32 = 32'(wlen_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (in_acc) state_nxt = S_EVICT;
      S_EVICT:     state_nxt = evict_need ? S_EVICT_RD : S_WRITE;
      S_EVICT_RD:  state_nxt = S_EVICT;
      S_WRITE:     state_nxt = S_SCAN;
      S_SCAN:      if (!scan_more && !pend_r) state_nxt = S_MEAN;
      S_MEAN:      state_nxt = S_MEAN_WAIT;
      S_MEAN_WAIT: if (drsp.done) state_nxt = S_MUL_LO;
      S_MUL_LO:    state_nxt = S_MUL_HI;
      S_MUL_HI:    state_nxt = S_DECIDE;
      S_DECIDE:    state_nxt = emit ? S_E_CM : S_IDLE;
      S_E_CM:      state_nxt = S_E_T;
      S_E_T:       state_nxt = S_E_MUL;
      S_E_MUL:     if (k_r == KW'(1)) state_nxt = S_P_DIV;
      S_P_DIV:     state_nxt = S_P_WAIT;
      S_P_WAIT:    if (drsp.done) state_nxt = S_PUT;
      S_PUT:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = scan_ptr_r;
    dreq.start = 1'b0;
    dreq.num   = e_r;
    dreq.den   = acc_cnt_r;
    case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_EVICT: begin
        rd_en   = evict_need;
        rd_addr = old_addr;
      end
      S_WRITE: mem_we = 1'b1;
      S_SCAN:  rd_en = scan_more;
      S_MEAN: begin
        dreq.start = 1'b1;
        dreq.num   = ACC_BITS'(total_r[TW-1] ? -total_r : total_r);
        dreq.den   = COUNT_BITS'(fill_r);
      end
      S_P_DIV: dreq.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // window memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[head_r] <= v_r;
    if (rd_en)  rd_data_r <= mem[rd_addr];
  end

  // threshold compare and search decision
  logic signed [QW-1:0]  vq, mean_q, lower_q, upper_q;
  logic                  up, lo;
  logic [COUNT_BITS-1:0] acc_cnt_nxt, snap_cnt_nxt;
  logic [ACC_BITS-1:0]   acc_sum_nxt, acc_sq_nxt, snap_sum_nxt, snap_sq_nxt;
  logic signed [SB-1:0]  trough_nxt, peak_nxt;
  logic [STAMP_BITS-1:0] tstamp_nxt, pstamp_nxt;
  logic                  seek_nxt;

  always_comb begin
    vq      = QW'(v_r) <<< 16;
    mean_q  = QW'(mean_r) <<< 16;
    lower_q = mean_q - QW'(prod_lo_r);
    upper_q = mean_q + QW'(prod_hi_r);
    up      = vq > upper_q;
    lo      = vq < lower_q;

    acc_cnt_nxt  = acc_cnt_r;
    acc_sum_nxt  = acc_sum_r;
    acc_sq_nxt   = acc_sq_r;
    snap_cnt_nxt = snap_cnt_r;
    snap_sum_nxt = snap_sum_r;
    snap_sq_nxt  = snap_sq_r;
    trough_nxt   = trough_r;
    tstamp_nxt   = tstamp_r;
    peak_nxt     = peak_r;
    pstamp_nxt   = pstamp_r;
    seek_nxt     = seek_r;
    emit         = 1'b0;

    // accumulation stops once the count is full
    if (acc_cnt_r != '1) begin
      acc_cnt_nxt = acc_cnt_r + 1'b1;
      acc_sum_nxt = acc_sum_r + ACC_BITS'(v_r);
      acc_sq_nxt  = acc_sq_r + ACC_BITS'(sq_r);
    end

    if (!seek_r) begin
      if (v_r < trough_r) begin
        trough_nxt  = v_r;
        tstamp_nxt  = vt_r;
        acc_cnt_nxt = '0;
        acc_sum_nxt = '0;
        acc_sq_nxt  = '0;
      end
    end else if (v_r > peak_r) begin
      peak_nxt     = v_r;
      pstamp_nxt   = vt_r;
      snap_cnt_nxt = acc_cnt_nxt;
      snap_sum_nxt = acc_sum_nxt;
      snap_sq_nxt  = acc_sq_nxt;
    end

    if (up && !seek_r) begin
      seek_nxt     = 1'b1;
      peak_nxt     = v_r;
      pstamp_nxt   = vt_r;
      snap_cnt_nxt = acc_cnt_nxt;
      snap_sum_nxt = acc_sum_nxt;
      snap_sq_nxt  = acc_sq_nxt;
    end else if (lo) begin
      if (seek_r) begin
        // cut the sums back to the peak
        if (snap_cnt_nxt <= acc_cnt_nxt) begin
          acc_cnt_nxt = snap_cnt_nxt;
          acc_sum_nxt = snap_sum_nxt;
          acc_sq_nxt  = snap_sq_nxt;
        end
        emit       = ovf_r;
        trough_nxt = v_r;
        tstamp_nxt = vt_r;
      end
      seek_nxt = 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      fill_r     <= '0;
      total_r    <= '0;
      ovf_r      <= 1'b0;
      seek_r     <= 1'b0;
      trough_r   <= {1'b0, {(SB-1){1'b1}}};
      peak_r     <= {1'b1, {(SB-1){1'b0}}};
      tstamp_r   <= '0;
      pstamp_r   <= '0;
      acc_cnt_r  <= '0;
      acc_sum_r  <= '0;
      acc_sq_r   <= '0;
      snap_cnt_r <= '0;
      snap_sum_r <= '0;
      snap_sq_r  <= '0;
      pend_r     <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            v_r   <= in_sample;
            vt_r  <= in_sample_time;
            len_r <= FW'(len32);
          end
        end
        S_EVICT_RD: begin
          total_r <= total_r - TW'(rd_data_r);
          fill_r  <= fill_r - 1'b1;
          ovf_r   <= 1'b1;
        end
        S_WRITE: begin
          total_r    <= total_r + TW'(v_r);
          head_r     <= (head_r == AW'(WINDOW_DEPTH - 1)) ? '0 : head_r + 1'b1;
          fill_r     <= fill_r + 1'b1;
          scan_ptr_r <= head_r;
          scan_cnt_r <= '0;
          pend_r     <= 1'b0;
          mn_r       <= v_r;
          mx_r       <= v_r;
        end
        S_SCAN: begin
          // read one entry per cycle, compare it the cycle after
          if (scan_more) begin
            scan_ptr_r <= (scan_ptr_r == '0) ? AW'(WINDOW_DEPTH - 1) : scan_ptr_r - 1'b1;
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end
          pend_r <= scan_more;
          if (pend_r) begin
            if (rd_data_r < mn_r) mn_r <= rd_data_r;
            if (rd_data_r > mx_r) mx_r <= rd_data_r;
          end
        end
        S_MEAN_WAIT: begin
          if (drsp.done) begin
            mean_r <= total_r[TW-1] ? -drsp.quo[SB-1:0] : drsp.quo[SB-1:0];
          end
        end
        S_MUL_LO: begin
          prod_lo_r <= PW'($signed({1'b0, keep_r})) *
                       PW'((SB+1)'(mean_r) - (SB+1)'(mn_r));
          sq_r      <= SQW'(v_r) * SQW'(v_r);
        end
        S_MUL_HI: begin
          prod_hi_r <= PW'($signed({1'b0, keep_r})) *
                       PW'((SB+1)'(mx_r) - (SB+1)'(mean_r));
        end
        S_DECIDE: begin
          acc_cnt_r  <= acc_cnt_nxt;
          acc_sum_r  <= acc_sum_nxt;
          acc_sq_r   <= acc_sq_nxt;
          snap_cnt_r <= snap_cnt_nxt;
          snap_sum_r <= snap_sum_nxt;
          snap_sq_r  <= snap_sq_nxt;
          trough_r   <= trough_nxt;
          tstamp_r   <= tstamp_nxt;
          peak_r     <= peak_nxt;
          pstamp_r   <= pstamp_nxt;
          seek_r     <= seek_nxt;
          // beat fields use the trough as it stood before this sample
          beat_start_r  <= tstamp_r;
          beat_dur_r    <= pstamp_nxt - tstamp_r;
          beat_peak_r   <= peak_nxt;
          beat_trough_r <= trough_r;
        end
        S_E_CM: begin
          cm_r <= ACC_BITS'(CMW'($signed({1'b0, acc_cnt_r})) * CMW'(beat_trough_r));
        end
        S_E_T: begin
          // energy = squares + m * (count*m - 2*sum), all mod 2^64
          tm_r  <= cm_r - {acc_sum_r[ACC_BITS-2:0], 1'b0};
          e_r   <= acc_sq_r;
          msh_r <= beat_trough_r;
          k_r   <= KW'(SB);
        end
        S_E_MUL: begin
          // one bit of m per cycle, top bit carries negative weight
          if (msh_r[0]) begin
            e_r <= (k_r == KW'(1)) ? e_r - tm_r : e_r + tm_r;
          end
          tm_r  <= {tm_r[ACC_BITS-2:0], 1'b0};
          msh_r <= msh_r >> 1;
          k_r   <= k_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_PUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PUT && out_free) begin
      out_beat_begin   <= beat_start_r;
      out_duration     <= beat_dur_r;
      out_peak_value   <= beat_peak_r;
      out_trough_value <= beat_trough_r;
      out_energy       <= sat48(e_r);
      out_power        <= (acc_cnt_r == '0) ? '0 : sat48(drsp.quo);
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### sv/pbd_chk.sv
// ----------------------------------------------------------------------------
// pbd_chk: port-level checks for the pulse beat detector
// Watches the handshakes and beat words; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_chk #(
  parameter int SAMPLE_BITS = pbd_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [SAMPLE_BITS-1:0]      out_peak_value,
  input wire logic [pbd_pkg::ENERGY_BITS-1:0]    out_energy,
  input wire logic [pbd_pkg::ENERGY_BITS-1:0]    out_power
);
  import pbd_pkg::*;

  // a held word keeps its energy and peak value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_energy) && $stable(out_peak_value))
    else $error("beat word changed while stalled");

  // one sample at a time: busy right after an accepted word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted before the first finished");

  // a new beat word only comes out of a busy cycle
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("beat word appeared while idle");

  // power never exceeds energy
  a_pow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_power <= out_energy)
    else $error("power above energy");

endmodule

bind pulse_beat_detector_unit pbd_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_pbd_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_peak_value (out_peak_value),
  .out_energy     (out_energy),
  .out_power      (out_power)
);

`default_nettype wire
